// ===== rtl/kcc_pkg.sv =====
// Shared types and constants for the key click classifier.
`default_nettype none
package kcc_pkg;

    localparam int unsigned CfgAddrWidth = 4;
    localparam int unsigned CfgDataWidth = 32;

    typedef enum logic [1:0] {
        REG_PIN_SELECT   = 2'd0,
        REG_LONG_TICKS   = 2'd1,
        REG_DOUBLE_TICKS = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } key_event_t;

    typedef enum logic [1:0] {
        PIN_KEY1    = 2'd0,
        PIN_KEY2    = 2'd1,
        PIN_NEEDLE  = 2'd2,
        PIN_OPENING = 2'd3
    } pin_sel_t;

    localparam logic [7:0] LongTicksReset   = 8'd100;
    localparam logic [7:0] DoubleTicksReset = 8'd10;

    typedef struct packed {
        logic [1:0] pin_select;
        logic [7:0] long_press_ticks;
        logic [7:0] double_click_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/kcc_cfg_regs.sv =====
// APB configuration registers of the key click classifier.
`default_nettype none
module kcc_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kcc_pkg::CfgAddrWidth-1:0]  paddr,
    input  wire logic [kcc_pkg::CfgDataWidth-1:0]  pwdata,
    output logic      [kcc_pkg::CfgDataWidth-1:0]  prdata,
    output logic                                   pready,
    output kcc_pkg::cfg_t                          cfg
);

    kcc_pkg::cfg_t      cfg_reg;
    kcc_pkg::cfg_t      cfg_next;
    kcc_pkg::reg_index_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = kcc_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                kcc_pkg::REG_PIN_SELECT:   cfg_next.pin_select         = pwdata[1:0];
                kcc_pkg::REG_LONG_TICKS:   cfg_next.long_press_ticks   = pwdata[7:0];
                kcc_pkg::REG_DOUBLE_TICKS: cfg_next.double_click_ticks = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_select         <= 2'd0;
            cfg_reg.long_press_ticks   <= kcc_pkg::LongTicksReset;
            cfg_reg.double_click_ticks <= kcc_pkg::DoubleTicksReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            kcc_pkg::REG_PIN_SELECT:   prdata[1:0] = cfg_reg.pin_select;
            kcc_pkg::REG_LONG_TICKS:   prdata[7:0] = cfg_reg.long_press_ticks;
            kcc_pkg::REG_DOUBLE_TICKS: prdata[7:0] = cfg_reg.double_click_ticks;
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/kcc_core.sv =====
// Debounce/press timing machine and click window machine, one tick per enable.
`default_nettype none
module kcc_core
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  kcc_pkg::cfg_t      cfg,
    input  wire logic          tick,
    input  wire logic [3:0]    levels,
    output kcc_pkg::key_event_t key_event
);

    typedef enum logic [3:0] {
        DB_IDLE    = 4'b0001,
        DB_CONFIRM = 4'b0010,
        DB_HOLD    = 4'b0100,
        DB_WAIT    = 4'b1000
    } db_state_t;

    typedef enum logic [1:0] {
        CL_IDLE    = 2'b01,
        CL_PENDING = 2'b10
    } cl_state_t;

    db_state_t           db_reg, db_next;
    cl_state_t           cl_reg, cl_next;
    logic [7:0]          hold_reg, hold_next, hold_inc;
    logic [7:0]          win_reg, win_next, win_inc;
    logic                level;
    logic                pressed;
    kcc_pkg::key_event_t low_ev;

    always_comb
    begin
        case (kcc_pkg::pin_sel_t'(cfg.pin_select))
            kcc_pkg::PIN_KEY1:    level = levels[0];
            kcc_pkg::PIN_KEY2:    level = levels[1];
            kcc_pkg::PIN_NEEDLE:  level = levels[2];
            default:              level = levels[3];
        endcase
    end

    assign pressed  = ~level;
    assign hold_inc = hold_reg + 8'd1;
    assign win_inc  = win_reg + 8'd1;

    always_comb
    begin
        db_next   = db_reg;
        hold_next = hold_reg;
        low_ev    = kcc_pkg::EV_NONE;
        unique case (db_reg)
            DB_IDLE:
            begin
                if (pressed)
                    db_next = DB_CONFIRM;
            end
            DB_CONFIRM:
            begin
                if (pressed)
                begin
                    hold_next = 8'd0;
                    db_next   = DB_HOLD;
                end
                else
                    db_next = DB_IDLE;
            end
            DB_HOLD:
            begin
                if (!pressed)
                begin
                    low_ev  = kcc_pkg::EV_SINGLE;
                    db_next = DB_IDLE;
                end
                else
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.long_press_ticks)
                    begin
                        low_ev  = kcc_pkg::EV_LONG;
                        db_next = DB_WAIT;
                    end
                end
            end
            DB_WAIT:
            begin
                if (!pressed)
                    db_next = DB_IDLE;
            end
            default:
            begin
                db_next = DB_IDLE;
            end
        endcase
    end

    // long press while a click is pending is dropped
    always_comb
    begin
        cl_next   = cl_reg;
        win_next  = win_reg;
        key_event = kcc_pkg::EV_NONE;
        unique case (cl_reg)
            CL_IDLE:
            begin
                if (low_ev == kcc_pkg::EV_SINGLE)
                begin
                    win_next = 8'd0;
                    cl_next  = CL_PENDING;
                end
                else
                    key_event = low_ev;
            end
            CL_PENDING:
            begin
                if (low_ev == kcc_pkg::EV_SINGLE)
                begin
                    key_event = kcc_pkg::EV_DOUBLE;
                    cl_next   = CL_IDLE;
                end
                else
                begin
                    win_next = win_inc;
                    if (win_inc >= cfg.double_click_ticks)
                    begin
                        key_event = kcc_pkg::EV_SINGLE;
                        cl_next   = CL_IDLE;
                    end
                end
            end
            default:
            begin
                cl_next = CL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg   <= DB_IDLE;
            cl_reg   <= CL_IDLE;
            hold_reg <= 8'd0;
            win_reg  <= 8'd0;
        end
        else if (tick)
        begin
            db_reg   <= db_next;
            cl_reg   <= cl_next;
            hold_reg <= hold_next;
            win_reg  <= win_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/key_click_classifier_unit.sv =====
// Top level of the key click classifier: stream channels, APB port and result register.
//
// Usage:
//   Each scan tick enters as one transfer on the s_ group; s_tdata[3:0]
//   carries the four active-low pin levels. For every input transfer one
//   result transfer leaves on the m_ group with the key event in
//   m_tdata[1:0] (0 none, 1 single, 2 double, 3 long).
//   The event is held in the result register in the cycle after the input
//   transfer. Throughput is one tick per cycle; the
//   input is taken whenever the result register is empty or is being
//   emptied in the same cycle, so a stalled receiver holds the result and
//   stops the input after one item, with no loss.
//   Registers (APB, byte addresses): 0x0 pin_select, 0x4 long_press_ticks,
//   0x8 double_click_ticks. Write them only while the block is idle.
//   Reset clears both machines, the counters and the result valid, and
//   loads pin_select 0, long_press_ticks 100, double_click_ticks 10.
`default_nettype none
module key_click_classifier_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] level_key1, [1] level_key2, [2] level_needle, [3] level_opening
    input  wire logic [7:0]                        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] key_event
    output logic      [7:0]                        m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kcc_pkg::CfgAddrWidth-1:0]  paddr,
    input  wire logic [kcc_pkg::CfgDataWidth-1:0]  pwdata,
    output logic      [kcc_pkg::CfgDataWidth-1:0]  prdata,
    output logic                                   pready
);

    kcc_pkg::cfg_t       cfg;
    kcc_pkg::key_event_t ev;
    logic                tick;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_event_reg;

    kcc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = ~out_valid_reg | m_tready;
    assign tick     = s_tvalid & s_tready;

    kcc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tick      (tick),
        .levels    (s_tdata[3:0]),
        .key_event (ev)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tick)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
            out_event_reg <= ev;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_event_reg};

endmodule
`default_nettype wire
